/* hw/rtl/xcfr_pkg.sv */
// Shared constants and types of the XOR-checked frame receiver.
package xcfr_pkg;

  localparam int unsigned MaxPayload = 16;
  localparam int unsigned PosW       = $clog2(MaxPayload);
  localparam int unsigned CntW       = $clog2(MaxPayload + 1);
  localparam int unsigned NumBanks   = 2;
  localparam int unsigned BankW      = $clog2(NumBanks);
  localparam int unsigned AddrW      = BankW + PosW;
  localparam int unsigned RamDepth   = NumBanks * MaxPayload;
  localparam int unsigned CfgIdxW    = 2;

  // Largest legal length byte: command plus a full payload.
  localparam logic [7:0] LenMax = 8'(MaxPayload + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEAD = 2'd0,
    CFG_ADDR = 2'd1,
    CFG_END  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] head_byte;
    logic [7:0] address_byte;
    logic [7:0] end_byte;
  } cfg_t;

  // Frame descriptor handed from front to back.
  typedef struct packed {
    logic [7:0]      command;
    logic [CntW-1:0] count;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } push_t;

endpackage

/* hw/rtl/xor_checked_frame_receiver_core.sv */
// Top level of the XOR-checked serial frame receiver.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o, rx_byte_i): one received byte per
//    request. Frames are head, address, length, command, payload, xor, end.
//  - Output channel (out_valid_o/out_ready_i): per good frame one header
//    result (kind 0) then one result per payload byte (kind 1); last_o marks
//    the final result of the frame. Bad frames produce nothing.
//  - Config channel (cfg_valid_i/cfg_ready_o): index 0 head byte, 1 address
//    byte, 2 end byte; other indexes are ignored. Always ready.
//  Throughput: one input byte per cycle. The parser only stalls when a frame
//  reaches its command byte while both frame buffer banks still await
//  draining. A payload result takes a RAM read, then a result register load;
//  a header loads directly. The end byte request registers the frame
//  descriptor and bank busy flag before the header result is loaded.
//  Reset: parser hunts for a head byte, config registers are zero, both
//  banks are free. A stalled receiver only holds the result register; the
//  parser keeps taking bytes until both banks are full.
module xor_checked_frame_receiver_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [xcfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output logic [7:0]                    command_o,
  output logic [xcfr_pkg::CntW-1:0]     payload_count_o,
  output logic [7:0]                    data_byte_o,
  output logic [xcfr_pkg::PosW-1:0]     byte_index_o,
  output logic                          last_o
);

  xcfr_pkg::cfg_t                  cfg_q;
  xcfr_pkg::push_t                 push;
  xcfr_pkg::desc_t                 desc_q [xcfr_pkg::NumBanks];
  logic [xcfr_pkg::NumBanks-1:0]   busy_q;
  logic [xcfr_pkg::NumBanks-1:0]   busy_d;
  logic [xcfr_pkg::BankW-1:0]      wr_bank_q;
  logic [xcfr_pkg::BankW-1:0]      rd_bank_q;
  logic                            release_bank;
  logic                            ram_we;
  logic [xcfr_pkg::AddrW-1:0]      ram_waddr;
  logic [7:0]                      ram_wdata;
  logic [xcfr_pkg::AddrW-1:0]      ram_raddr;
  logic [7:0]                      ram_rdata;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (xcfr_pkg::cfg_idx_e'(cfg_index_i))
        xcfr_pkg::CFG_HEAD: cfg_q.head_byte    <= cfg_data_i;
        xcfr_pkg::CFG_ADDR: cfg_q.address_byte <= cfg_data_i;
        xcfr_pkg::CFG_END:  cfg_q.end_byte     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Bank ownership: set on push, cleared on release.
  always_comb begin
    busy_d = busy_q;
    if (push.valid) begin
      busy_d[wr_bank_q] = 1'b1;
    end
    if (release_bank) begin
      busy_d[rd_bank_q] = 1'b0;
    end
  end

  // Two-entry frame queue; each entry owns one payload bank.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= '0;
      wr_bank_q <= '0;
      rd_bank_q <= '0;
      for (int i = 0; i < xcfr_pkg::NumBanks; i++) begin
        desc_q[i] <= '0;
      end
    end else begin
      busy_q <= busy_d;
      if (push.valid) begin
        desc_q[wr_bank_q] <= push.desc;
        wr_bank_q         <= wr_bank_q + 1'b1;
      end
      if (release_bank) begin
        rd_bank_q <= rd_bank_q + 1'b1;
      end
    end
  end

  xcfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg_q),
    .wr_bank_i   (wr_bank_q),
    .slot_busy_i (busy_q[wr_bank_q]),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .push_o      (push)
  );

  xcfr_ram #(
    .Width (8),
    .Depth (xcfr_pkg::RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  xcfr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .avail_i         (busy_q[rd_bank_q]),
    .desc_i          (desc_q[rd_bank_q]),
    .rd_bank_i       (rd_bank_q),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .release_o       (release_bank),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .command_o       (command_o),
    .payload_count_o (payload_count_o),
    .data_byte_o     (data_byte_o),
    .byte_index_o    (byte_index_o),
    .last_o          (last_o)
  );

  // A frame is only queued into a free bank.
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !busy_q[wr_bank_q])
    else $error("frame queued into busy bank");

  // Only an owned bank is handed back.
  a_release_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    release_bank |-> busy_q[rd_bank_q])
    else $error("release of a free bank");

  // Last payload result sits at the final index.
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o && last_o) |->
      (({1'b0, byte_index_o} + xcfr_pkg::CntW'(1)) == payload_count_o))
    else $error("last flag on wrong payload index");

  // Payload results only exist for frames with payload.
  a_payload_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o) |-> (payload_count_o != '0))
    else $error("payload result of an empty frame");

endmodule

/* hw/rtl/xcfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module xcfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/xcfr_front.sv */
// Front end: byte-wise frame parser, payload capture and checksum test.
module xcfr_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                rx_byte_i,
  input  xcfr_pkg::cfg_t            cfg_i,
  input  logic [xcfr_pkg::BankW-1:0] wr_bank_i,
  input  logic                      slot_busy_i,
  output logic                      ram_we_o,
  output logic [xcfr_pkg::AddrW-1:0] ram_addr_o,
  output logic [7:0]                ram_wdata_o,
  output xcfr_pkg::push_t           push_o
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_ADDR, PH_LEN, PH_CMD, PH_DATA, PH_XOR, PH_END
  } phase_e;

  phase_e                     phase_q;
  logic [xcfr_pkg::CntW-1:0]  cnt_q;
  logic [xcfr_pkg::CntW-1:0]  left_q;
  logic [xcfr_pkg::PosW-1:0]  pos_q;
  logic [7:0]                 xor_q;
  logic [7:0]                 cmd_q;
  logic                       accept;
  logic                       in_frame_body;
  phase_e                     hunt_next;

  // Once past the length byte the frame needs a free buffer bank.
  assign in_frame_body = (phase_q == PH_CMD) || (phase_q == PH_DATA) ||
                         (phase_q == PH_XOR) || (phase_q == PH_END);
  assign in_ready_o    = !(slot_busy_i && in_frame_body);
  assign accept        = in_valid_i && in_ready_o;
  assign hunt_next     = (rx_byte_i == cfg_i.head_byte) ? PH_ADDR : PH_HUNT;

  assign ram_we_o    = accept && (phase_q == PH_DATA);
  assign ram_addr_o  = {wr_bank_i, pos_q};
  assign ram_wdata_o = rx_byte_i;

  assign push_o.valid        = accept && (phase_q == PH_END) && (rx_byte_i == cfg_i.end_byte);
  assign push_o.desc.command = cmd_q;
  assign push_o.desc.count   = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      left_q  <= '0;
      pos_q   <= '0;
      xor_q   <= '0;
      cmd_q   <= '0;
    end else if (accept) begin
      case (phase_q)
        PH_HUNT: begin
          phase_q <= hunt_next;
        end
        PH_ADDR: begin
          phase_q <= (rx_byte_i == cfg_i.address_byte) ? PH_LEN : hunt_next;
        end
        PH_LEN: begin
          if (rx_byte_i == 8'd0 || rx_byte_i > xcfr_pkg::LenMax) begin
            phase_q <= hunt_next;
          end else begin
            cnt_q   <= xcfr_pkg::CntW'(rx_byte_i - 8'd1);
            xor_q   <= rx_byte_i;
            phase_q <= PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_q   <= rx_byte_i;
          xor_q   <= xor_q ^ rx_byte_i;
          left_q  <= cnt_q;
          pos_q   <= '0;
          phase_q <= (cnt_q == '0) ? PH_XOR : PH_DATA;
        end
        PH_DATA: begin
          xor_q  <= xor_q ^ rx_byte_i;
          pos_q  <= pos_q + 1'b1;
          left_q <= left_q - 1'b1;
          if (left_q == xcfr_pkg::CntW'(1)) begin
            phase_q <= PH_XOR;
          end
        end
        PH_XOR: begin
          phase_q <= (rx_byte_i == xor_q) ? PH_END : hunt_next;
        end
        PH_END: begin
          phase_q <= (rx_byte_i == cfg_i.end_byte) ? PH_HUNT : hunt_next;
        end
        default: begin
          phase_q <= hunt_next;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/xcfr_back.sv */
// Back end: walks one stored frame and drives the result register.
module xcfr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       avail_i,
  input  xcfr_pkg::desc_t            desc_i,
  input  logic [xcfr_pkg::BankW-1:0] rd_bank_i,
  output logic [xcfr_pkg::AddrW-1:0] ram_raddr_o,
  input  logic [7:0]                 ram_rdata_i,
  output logic                       release_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       kind_o,
  output logic [7:0]                 command_o,
  output logic [xcfr_pkg::CntW-1:0]  payload_count_o,
  output logic [7:0]                 data_byte_o,
  output logic [xcfr_pkg::PosW-1:0]  byte_index_o,
  output logic                       last_o
);

  typedef enum logic [1:0] {
    B_IDLE, B_READ, B_LOAD
  } bstate_e;

  bstate_e                   state_q;
  logic [xcfr_pkg::PosW-1:0] idx_q;
  logic                      out_free;
  logic                      out_load;
  logic                      idx_last;

  assign out_free    = !out_valid_o || out_ready_i;
  // result register takes a new result this cycle
  assign out_load    = out_free &&
                       (((state_q == B_IDLE) && avail_i) || (state_q == B_LOAD));
  assign idx_last    = ({1'b0, idx_q} + xcfr_pkg::CntW'(1)) == desc_i.count;
  assign ram_raddr_o = {rd_bank_i, idx_q};
  assign release_o   = out_free &&
                       (((state_q == B_IDLE) && avail_i && (desc_i.count == '0)) ||
                        ((state_q == B_LOAD) && idx_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= B_IDLE;
      idx_q           <= '0;
      out_valid_o     <= 1'b0;
      kind_o          <= 1'b0;
      command_o       <= '0;
      payload_count_o <= '0;
      data_byte_o     <= '0;
      byte_index_o    <= '0;
      last_o          <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && !out_load) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (avail_i && out_free) begin
            // header result
            out_valid_o     <= 1'b1;
            kind_o          <= 1'b0;
            command_o       <= desc_i.command;
            payload_count_o <= desc_i.count;
            data_byte_o     <= '0;
            byte_index_o    <= '0;
            last_o          <= (desc_i.count == '0);
            idx_q           <= '0;
            if (desc_i.count != '0) begin
              state_q <= B_READ;
            end
          end
        end
        B_READ: begin
          // address settles; read data is valid next cycle
          state_q <= B_LOAD;
        end
        B_LOAD: begin
          if (out_free) begin
            out_valid_o     <= 1'b1;
            kind_o          <= 1'b1;
            command_o       <= desc_i.command;
            payload_count_o <= desc_i.count;
            data_byte_o     <= ram_rdata_i;
            byte_index_o    <= idx_q;
            last_o          <= idx_last;
            if (idx_last) begin
              state_q <= B_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= B_READ;
            end
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule
